### design/ttd_pkg.sv
// ----------------------------------------------------------------------------
// ttd_pkg: shared constants and types for the tilt threshold haptic drive
// Widths, pipeline depths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ttd_pkg;

   localparam int ACCEL_W      = 16;
   localparam int SUM_W        = 32;
   localparam int ROOT_W       = 24;
   localparam int REM_W        = ROOT_W + 3;
   localparam int RAD_W        = 2 * ROOT_W;
   localparam int SQRT_STAGES  = ROOT_W;
   localparam int CORDIC_STAGES = 16;
   localparam int CORDIC_LAT   = CORDIC_STAGES + 1;
   localparam int XY_W         = 28;
   localparam int Z_W          = 26;
   localparam int ACC_FRAC     = 16;
   localparam int ANGLE_FRAC_BITS = 4;
   localparam int RND_SHIFT    = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int PIPE_LAT     = 3 + SQRT_STAGES + CORDIC_LAT + 1;

   localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180 <<< ACC_FRAC);

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_ROLL  = 2'd1;
   localparam logic [1:0] REG_PITCH = 2'd2;
   localparam logic [1:0] REG_DUTY  = 2'd3;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] px;
      logic signed [ACCEL_W-1:0] by;
      logic signed [ACCEL_W-1:0] bz;
   } side_type;

   // round(atan(2^-i) deg * 65536)
   function automatic logic signed [Z_W-1:0] atan_tab(input int i);
      logic signed [Z_W-1:0] v;
      case (i)
         0: v = Z_W'(2949120);
         1: v = Z_W'(1740967);
         2: v = Z_W'(919879);
         3: v = Z_W'(466945);
         4: v = Z_W'(234379);
         5: v = Z_W'(117304);
         6: v = Z_W'(58666);
         7: v = Z_W'(29335);
         8: v = Z_W'(14668);
         9: v = Z_W'(7334);
         10: v = Z_W'(3667);
         11: v = Z_W'(1833);
         12: v = Z_W'(917);
         13: v = Z_W'(458);
         14: v = Z_W'(229);
         15: v = Z_W'(115);
         16: v = Z_W'(57);
         17: v = Z_W'(29);
         18: v = Z_W'(14);
         19: v = Z_W'(7);
         20: v = Z_W'(4);
         21: v = Z_W'(2);
         22: v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### design/ttd_isqrt.sv
// ----------------------------------------------------------------------------
// ttd_isqrt: pipelined integer square root
// floor(sqrt(sum * 65536)), one result bit per stage, side data carried along.
// ----------------------------------------------------------------------------
module ttd_isqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [ttd_pkg::SUM_W-1:0]    sum_in,
   input  ttd_pkg::side_type            side_in,
   output logic [ttd_pkg::ROOT_W-1:0]   root_out,
   output ttd_pkg::side_type            side_out
);
   import ttd_pkg::*;

   logic [RAD_W-1:0]  rad_ff  [0:SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff  [0:SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [0:SQRT_STAGES];
   side_type          side_ff [0:SQRT_STAGES];

   assign rad_ff[0]  = {sum_in, 16'd0};
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;
   assign side_ff[0] = side_in;

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [REM_W-1:0]  rem_in;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_nx;
      logic [ROOT_W-1:0] root_nx;

      always_comb begin
         rem_in = {rem_ff[k][REM_W-3:0], rad_ff[k][RAD_W-1:RAD_W-2]};
         trial  = REM_W'({root_ff[k], 2'b01});
         if (rem_in >= trial) begin
            rem_nx  = rem_in - trial;
            root_nx = {root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_nx  = rem_in;
            root_nx = {root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k+1]  <= {rad_ff[k][RAD_W-3:0], 2'b00};
            rem_ff[k+1]  <= rem_nx;
            root_ff[k+1] <= root_nx;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES];
   assign side_out = side_ff[SQRT_STAGES];

endmodule

### design/ttd_cordic.sv
// ----------------------------------------------------------------------------
// ttd_cordic: pipelined vectoring CORDIC atan2
// Quadrant fold stage then one micro-rotation per stage; angle in 2^-16 deg.
// ----------------------------------------------------------------------------
module ttd_cordic (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [ttd_pkg::XY_W-1:0]    y_in,
   input  logic signed [ttd_pkg::XY_W-1:0]    x_in,
   output logic signed [ttd_pkg::Z_W-1:0]     z_out
);
   import ttd_pkg::*;

   logic signed [XY_W-1:0] x_ff [0:CORDIC_STAGES];
   logic signed [XY_W-1:0] y_ff [0:CORDIC_STAGES];
   logic signed [Z_W-1:0]  z_ff [0:CORDIC_STAGES];
   logic                   hold_ff [0:CORDIC_STAGES];

   // fold left half plane, pin the y == 0 case
   always_ff @(posedge clock) begin
      if (en) begin
         hold_ff[0] <= (y_in == '0);
         if (y_in == '0) begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= (x_in < 0) ? HALF_TURN : '0;
         end else if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= (y_in > 0) ? HALF_TURN : -HALF_TURN;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      localparam logic signed [Z_W-1:0] ANG = atan_tab(i);
      always_ff @(posedge clock) begin
         if (en) begin
            hold_ff[i+1] <= hold_ff[i];
            if (hold_ff[i]) begin
               x_ff[i+1] <= x_ff[i];
               y_ff[i+1] <= y_ff[i];
               z_ff[i+1] <= z_ff[i];
            end else if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ANG;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ANG;
            end
         end
      end
   end

   assign z_out = z_ff[CORDIC_STAGES];

endmodule

### design/tilt_threshold_haptic_drive.sv
// ----------------------------------------------------------------------------
// tilt_threshold_haptic_drive: accelerometer tilt to haptic motor duties
// Roll/pitch by pipelined CORDIC atan2, thresholds drive four motor duties.
// ----------------------------------------------------------------------------
// A new request is taken every cycle while the pipe is not held; each result
// passes input, square, sum, 24 square-root stages, 17 CORDIC stages and
// output. The whole pipeline advances together: while a result waits on
// rsp_tready the pipe holds and req_tready is low, a bubble-free stream
// otherwise. Roll = atan2(back y, back z); pitch = atan2(x, sqrt(y^2+z^2))
// of the neck sensor (dual mode) or back sensor. Angles are in 1/16 degree.
// Configuration must be written through csr_ only while the block is idle; the block does not enforce this.
module tilt_threshold_haptic_drive (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // back_accel_x, back_accel_y, back_accel_z, neck_accel_x, neck_accel_y,
   // neck_accel_z (16 bits each, from bit 0 up)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // roll_angle[12:0], pitch_angle[24:13], back_left_duty[32:25],
   // back_right_duty[40:33], neck_up_duty[48:41], neck_down_duty[56:49], zeros
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ttd_pkg::*;

   // configuration registers
   logic        mode_ff;
   logic [11:0] roll_lim_ff;
   logic [10:0] pitch_lim_ff;
   logic [7:0]  duty_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         roll_lim_ff  <= 12'd240;
         pitch_lim_ff <= 11'd160;
         duty_ff      <= 8'd150;
      end else if (csr_valid && csr_index[7:2] == '0) begin
         case (csr_index[1:0])
            REG_MODE:  mode_ff      <= csr_wdata[0];
            REG_ROLL:  roll_lim_ff  <= csr_wdata[11:0];
            REG_PITCH: pitch_lim_ff <= csr_wdata[10:0];
            REG_DUTY:  duty_ff      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // pipeline control: all stages step together
   logic                en;
   logic [PIPE_LAT-1:0] vld_ff;

   assign en         = !vld_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   // stage 1: pick the pitch sensor
   side_type                  s1_side_ff;
   logic signed [ACCEL_W-1:0] s1_py_ff, s1_pz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff.by <= req_tdata[31:16];
         s1_side_ff.bz <= req_tdata[47:32];
         if (mode_ff) begin
            s1_side_ff.px <= req_tdata[63:48];
            s1_py_ff      <= req_tdata[79:64];
            s1_pz_ff      <= req_tdata[95:80];
         end else begin
            s1_side_ff.px <= req_tdata[15:0];
            s1_py_ff      <= req_tdata[31:16];
            s1_pz_ff      <= req_tdata[47:32];
         end
      end
   end

   // stage 2: squares
   side_type         s2_side_ff;
   logic [SUM_W-2:0] s2_yy_ff, s2_zz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_side_ff <= s1_side_ff;
         s2_yy_ff   <= (SUM_W-1)'(s1_py_ff * s1_py_ff);
         s2_zz_ff   <= (SUM_W-1)'(s1_pz_ff * s1_pz_ff);
      end
   end

   // stage 3: exact sum
   side_type         s3_side_ff;
   logic [SUM_W-1:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_side_ff <= s2_side_ff;
         s3_sum_ff  <= {1'b0, s2_yy_ff} + {1'b0, s2_zz_ff};
      end
   end

   // magnitude = floor(sqrt(sum) * 256)
   logic [ROOT_W-1:0] mag;
   side_type          sq_side;

   ttd_isqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .sum_in   (s3_sum_ff),
      .side_in  (s3_side_ff),
      .root_out (mag),
      .side_out (sq_side)
   );

   // both atan2 run side by side so results stay aligned
   logic signed [XY_W-1:0] roll_y, roll_x, pitch_y, pitch_x;
   logic signed [Z_W-1:0]  roll_z, pitch_z;

   // scaled samples are sign-extended to the CORDIC width
   assign roll_y  = XY_W'($signed({sq_side.by, 8'd0}));
   assign roll_x  = XY_W'($signed({sq_side.bz, 8'd0}));
   assign pitch_y = XY_W'($signed({sq_side.px, 8'd0}));
   assign pitch_x = XY_W'({1'b0, mag});

   ttd_cordic u_roll (
      .clock (clock),
      .en    (en),
      .y_in  (roll_y),
      .x_in  (roll_x),
      .z_out (roll_z)
   );

   ttd_cordic u_pitch (
      .clock (clock),
      .en    (en),
      .y_in  (pitch_y),
      .x_in  (pitch_x),
      .z_out (pitch_z)
   );

   // output stage: round, clamp, thresholds
   localparam int R_W = Z_W - RND_SHIFT;
   localparam logic signed [R_W-1:0] ROLL_MAX  = R_W'(180 <<< ANGLE_FRAC_BITS);
   localparam logic signed [R_W-1:0] PITCH_MAX = R_W'(90 <<< ANGLE_FRAC_BITS);
   localparam logic signed [Z_W-1:0] HALF_LSB  = Z_W'(1 <<< (RND_SHIFT - 1));

   logic signed [Z_W-1:0] roll_rz, pitch_rz;
   logic signed [R_W-1:0] roll_r, pitch_r, roll_c, pitch_c, rl, pl;

   always_comb begin
      roll_rz  = roll_z + HALF_LSB;
      pitch_rz = pitch_z + HALF_LSB;
      roll_r   = R_W'(roll_rz >>> RND_SHIFT);
      pitch_r  = R_W'(pitch_rz >>> RND_SHIFT);
      roll_c   = roll_r;
      if (roll_r > ROLL_MAX)  roll_c = ROLL_MAX;
      if (roll_r < -ROLL_MAX) roll_c = -ROLL_MAX;
      pitch_c  = pitch_r;
      if (pitch_r > PITCH_MAX)  pitch_c = PITCH_MAX;
      if (pitch_r < -PITCH_MAX) pitch_c = -PITCH_MAX;
      rl = R_W'({1'b0, roll_lim_ff});
      pl = R_W'({1'b0, pitch_lim_ff});
   end

   logic [12:0] roll_ff;
   logic [11:0] pitch_ff;
   logic [7:0]  left_ff, right_ff, up_ff, down_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= roll_c[12:0];
         pitch_ff <= pitch_c[11:0];
         left_ff  <= (roll_c < -rl)  ? duty_ff : 8'd0;
         right_ff <= (roll_c > rl)   ? duty_ff : 8'd0;
         up_ff    <= (pitch_c > pl)  ? duty_ff : 8'd0;
         down_ff  <= (pitch_c < -pl) ? duty_ff : 8'd0;
      end
   end

   assign rsp_tdata = {7'd0, down_ff, up_ff, right_ff, left_ff, pitch_ff, roll_ff};

endmodule
